### hw/rtl/packet_slot_fifo_macros.svh
// Assertion macros shared by the packet slot FIFO RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef PACKET_SLOT_FIFO_MACROS_SVH
`define PACKET_SLOT_FIFO_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define PSF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/psf_pkg.sv
// Package for the packet slot FIFO: sizes, derived widths, codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package psf_pkg;

  // Geometry of the slot store.
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BYTES = 64;
  localparam int MEM_DEPTH  = SLOT_COUNT * SLOT_BYTES;

  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
  localparam int POS_W   = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Fixed field widths of the stream ports.
  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 7;
  localparam int KIND_W  = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_LONG   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_FULL = 2'd1,
    DROP_LONG = 2'd2
  } drop_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_do;    // handle one pushed byte and present its result
    logic empty_do;   // present the empty-pop result
    logic pop_start;  // latch the head length and read the first byte
    logic pop_emit;   // present the byte held in the read register
    logic pop_next;   // read the following byte of the head packet
    logic pop_done;   // release the head slot
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic empty;      // no committed packet
    logic pop_last;   // the byte in the read register ends the packet
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/psf_ctrl.sv
// Controller of the packet slot FIFO: idle/pop-stream state machine.
// Depends on psf_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none

module psf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  output logic                in_ready,
  input  wire psf_pkg::stat_t stat,
  output psf_pkg::cmd_t       cmd
);
  import psf_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && action_t'(in_action) == ACT_POP && !stat.empty) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (stat.out_free && stat.pop_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = stat.out_free;
        if (accept) begin
          if (action_t'(in_action) == ACT_PUSH) begin
            cmd.push_do = 1'b1;
          end else if (stat.empty) begin
            cmd.empty_do = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
          end
        end
      end
      ST_POP: begin
        if (stat.out_free) begin
          cmd.pop_emit = 1'b1;
          cmd.pop_next = !stat.pop_last;
          cmd.pop_done = stat.pop_last;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/psf_datapath.sv
// Datapath of the packet slot FIFO: slot store, lengths, pointers, packet
// builder and output register. Depends on psf_pkg and the assertion macros.
`default_nettype none

`include "packet_slot_fifo_macros.svh"

module psf_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire psf_pkg::cmd_t                      cmd,
  output psf_pkg::stat_t                          stat,
  input  wire logic [psf_pkg::BYTE_W-1:0]         in_byte,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [psf_pkg::KIND_W-1:0]              out_kind,
  output logic [psf_pkg::BYTE_W-1:0]              out_byte,
  output logic [psf_pkg::SIZE_W-1:0]              out_size,
  output logic                                    out_last
);
  import psf_pkg::*;

  // Storage: packet bytes and committed lengths.
  byte_t mem [MEM_DEPTH];
  pos_t  slot_length [SLOT_COUNT];

  // Pointers and packet builder state.
  slot_t  head_slot;
  slot_t  tail_slot;
  count_t packet_count;
  pos_t   fill_position;
  drop_t  drop_reason;

  // Pop stream state.
  pos_t   pop_len;
  pos_t   rd_idx;
  byte_t  rd_data;

  // Push evaluation.
  drop_t  drop_eff;
  logic   wr_en;
  addr_t  wr_addr;
  pos_t   fill_inc;
  kind_t  push_kind;
  pos_t   push_size;
  logic   commit;

  // Read side.
  logic   rd_en;
  addr_t  rd_addr;
  pos_t   rd_idx_inc;

  logic   out_free;

  assign out_free   = !out_valid || out_ready;
  assign fill_inc   = fill_position + 1'b1;
  assign rd_idx_inc = rd_idx + 1'b1;

  assign stat.out_free = out_free;
  assign stat.empty    = (packet_count == '0);
  assign stat.pop_last = (rd_idx_inc == pop_len);

  // A packet that meets a full FIFO at its first byte is dropped whole;
  // a byte beyond the slot size drops the packet from there on.
  always_comb begin
    drop_eff = drop_reason;
    wr_en    = 1'b0;
    if (fill_position == '0 && drop_reason == DROP_NONE &&
        packet_count == COUNT_W'(SLOT_COUNT)) begin
      drop_eff = DROP_FULL;
    end
    if (drop_eff == DROP_NONE) begin
      if (fill_position == POS_W'(SLOT_BYTES)) begin
        drop_eff = DROP_LONG;
      end else begin
        wr_en = cmd.push_do;
      end
    end
    case (drop_eff)
      DROP_FULL: push_kind = KIND_FULL;
      DROP_LONG: push_kind = KIND_LONG;
      default:   push_kind = KIND_ACCEPT;
    endcase
    commit    = cmd.push_do && in_last && (drop_eff == DROP_NONE);
    push_size = (in_last && drop_eff == DROP_NONE) ? fill_inc : '0;
  end

  assign wr_addr = addr_t'(ADDR_W'(tail_slot) * ADDR_W'(SLOT_BYTES))
                 + ADDR_W'(fill_position);

  // Read address: first byte at pop start, then the following byte.
  always_comb begin
    rd_en   = cmd.pop_start || cmd.pop_next;
    rd_addr = addr_t'(ADDR_W'(head_slot) * ADDR_W'(SLOT_BYTES));
    if (cmd.pop_next) begin
      rd_addr = rd_addr + ADDR_W'(rd_idx_inc);
    end
  end

  // Byte store, written by pushes, read with a registered output.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Lengths of committed slots, and the length of the packet being popped.
  always_ff @(posedge clk) begin
    if (commit) begin
      slot_length[tail_slot] <= fill_inc;
    end
    if (cmd.pop_start) begin
      pop_len <= slot_length[head_slot];
    end
  end

  // Pointers, packet count and the packet builder.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot     <= '0;
      tail_slot     <= '0;
      packet_count  <= '0;
      fill_position <= '0;
      drop_reason   <= DROP_NONE;
      rd_idx        <= '0;
    end else begin
      if (cmd.push_do) begin
        if (in_last) begin
          fill_position <= '0;
          drop_reason   <= DROP_NONE;
        end else begin
          drop_reason <= drop_eff;
          if (wr_en) begin
            fill_position <= fill_inc;
          end
        end
      end
      if (commit) begin
        tail_slot    <= (tail_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_slot + 1'b1;
        packet_count <= packet_count + 1'b1;
      end
      if (cmd.pop_done) begin
        head_slot    <= (head_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_slot + 1'b1;
        packet_count <= packet_count - 1'b1;
      end
      if (cmd.pop_start) begin
        rd_idx <= '0;
      end else if (cmd.pop_next) begin
        rd_idx <= rd_idx_inc;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_do || cmd.empty_do || cmd.pop_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.push_do) begin
      out_kind <= push_kind;
      out_byte <= '0;
      out_size <= SIZE_W'(push_size);
      out_last <= 1'b1;
    end else if (cmd.empty_do) begin
      out_kind <= KIND_EMPTY;
      out_byte <= '0;
      out_size <= '0;
      out_last <= 1'b1;
    end else if (cmd.pop_emit) begin
      out_kind <= KIND_POP;
      out_byte <= rd_data;
      out_size <= SIZE_W'(pop_len);
      out_last <= stat.pop_last;
    end
  end

  `PSF_NEVER(a_count_in_range, packet_count > COUNT_W'(SLOT_COUNT), "packet count exceeds slot count")
  `PSF_NEVER(a_fill_in_range, fill_position > POS_W'(SLOT_BYTES), "fill position exceeds slot size")
  `PSF_NEVER(a_pop_not_empty, cmd.pop_start && packet_count == '0, "pop started on empty FIFO")
  `PSF_ASSERT(a_pop_frees_slot, cmd.pop_done |=> packet_count == $past(packet_count) - 1'b1, "pop did not free a slot")
  `PSF_NEVER(a_load_when_busy, (cmd.push_do || cmd.empty_do || cmd.pop_emit) && !out_free, "result loaded over an untaken result")

endmodule

`default_nettype wire

### hw/rtl/packet_slot_fifo.sv
// Top level of the packet slot FIFO: joins controller and datapath.
// Depends on psf_pkg, psf_ctrl and psf_datapath.
//
//   Port group   Dir  tdata                          tuser        tlast
//   s_axis       in   [7:0] data_byte                [0] action   last_byte
//   m_axis       out  [7:0] out_byte, [14:8] size    [2:0] kind   last
//
// A push gives one transaction on m_axis.
// A pop of an n-byte packet does the registered store read first, then gives
// one byte per cycle while m_axis takes them; an empty pop gives one transaction.
// Synchronous reset clears pointers, count and packet state; the byte store
// and lengths are not cleared, so no clearing pass is needed.
// A low m_axis_tready holds a pending result in the output register and keeps s_axis_tready low.
`default_nettype none

module packet_slot_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [psf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  wire logic                               s_axis_tlast,  // last_byte
  input  wire logic                               s_axis_tuser,  // [0] action
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [psf_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // [7:0] out_byte, [14:8] packet_size
  output logic                                    m_axis_tlast,  // last
  output logic [psf_pkg::KIND_W-1:0]              m_axis_tuser   // [2:0] kind
);
  import psf_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic [BYTE_W-1:0]   res_byte;
  logic [SIZE_W-1:0]   res_size;

  // Sequencing of pushes and pop streams.
  psf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, pointers and output register.
  psf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (s_axis_tdata[BYTE_W-1:0]),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_byte  (res_byte),
    .out_size  (res_size),
    .out_last  (m_axis_tlast)
  );

  // Pack the result fields, padded to whole bytes.
  assign m_axis_tdata = {{(OUT_DATA_W - BYTE_W - SIZE_W){1'b0}}, res_size, res_byte};

endmodule

`default_nettype wire

### tb/sv/packet_slot_fifo_tb.sv
// Self-checking testbench for packet_slot_fifo. It runs directed and random push and pop
// traffic and checks every m_axis transaction against a behavioral FIFO model.
// Depends on psf_pkg and packet_slot_fifo.
`default_nettype none

module packet_slot_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psf_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  // Input transactions over the whole run; random traffic tops up after the directed tests.
  localparam int ITEM_TARGET = 450;

  // One m_axis transaction as the model predicts it.
  typedef struct {
    kind_t             kind;
    byte_t             out_byte;
    logic [SIZE_W-1:0] size;
    logic              last;
  } psf_result_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;   // [7:0] data_byte
  logic                    s_axis_tlast;   // last_byte
  logic                    s_axis_tuser;   // [0] action
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;   // [7:0] out_byte, [14:8] packet_size
  logic                    m_axis_tlast;   // last
  logic [KIND_W-1:0]       m_axis_tuser;   // [2:0] kind

  // Model state of the slot FIFO.
  byte_t       slot_image [SLOT_COUNT][SLOT_BYTES];
  int unsigned slot_len [SLOT_COUNT];
  int unsigned head_idx;
  int unsigned stored_packets;
  int unsigned fill_idx;
  drop_t       drop_state;

  psf_result_t fifo_outputs_due[$];
  int          mismatch_count;
  int          result_index;
  int          items_sent;
  int          rx_wait;
  int          idle_cycles;
  bit          no_gaps;

  packet_slot_fifo u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Queues one predicted result.
  task automatic add_result(kind_t kind, byte_t data, int unsigned size, logic fin);
    psf_result_t r;
    r.kind = kind;
    r.out_byte = data;
    r.size = size[SIZE_W-1:0];
    r.last = fin;
    fifo_outputs_due.push_back(r);
  endtask

  // Advances the FIFO model by one accepted input transaction.
  task automatic model_fifo_item(action_t act, byte_t data, logic fin);
    int unsigned tail;
    int unsigned size;
    kind_t       kind;
    size = 0;
    if (act == ACT_POP) begin
      if (stored_packets == 0) begin
        add_result(KIND_EMPTY, '0, 0, 1'b1);
      end else begin
        for (int i = 0; i < slot_len[head_idx]; i++)
          add_result(KIND_POP, slot_image[head_idx][i], slot_len[head_idx],
                     (i + 1 == slot_len[head_idx]));
        head_idx = (head_idx + 1) % SLOT_COUNT;
        stored_packets--;
      end
    end else begin
      tail = (head_idx + stored_packets) % SLOT_COUNT;
      // A packet that starts while every slot is taken is dropped whole.
      if (fill_idx == 0 && drop_state == DROP_NONE && stored_packets >= SLOT_COUNT)
        drop_state = DROP_FULL;
      if (drop_state == DROP_NONE) begin
        if (fill_idx >= SLOT_BYTES) begin
          drop_state = DROP_LONG;
        end else begin
          slot_image[tail][fill_idx] = data;
          fill_idx++;
        end
      end
      case (drop_state)
        DROP_FULL: kind = KIND_FULL;
        DROP_LONG: kind = KIND_LONG;
        default:   kind = KIND_ACCEPT;
      endcase
      // The final byte commits the packet unless it was dropped.
      if (fin) begin
        if (drop_state == DROP_NONE) begin
          slot_len[tail] = fill_idx;
          stored_packets++;
          size = fill_idx;
        end
        fill_idx = 0;
        drop_state = DROP_NONE;
      end
      add_result(kind, '0, size, 1'b1);
    end
  endtask

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string field, int got, int want);
    $display("ERROR: result %0d, %s is %0d, expected %0d", result_index, field, got, want);
    mismatch_count++;
  endtask

  // Sends one input transaction after a random gap and updates the model on acceptance.
  task automatic send_item(action_t act, byte_t data, logic fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= fin;
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    model_fifo_item(act, data, fin);
  endtask

  // Pushes one packet of random bytes, with pops slipped in between bytes at the given rate.
  task automatic send_packet(int len, int pop_pct);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) < pop_pct)
        send_item(ACT_POP, byte_t'($urandom), logic'($urandom_range(0, 1)));
      send_item(ACT_PUSH, byte_t'($urandom), (i == len - 1));
    end
  endtask

  task automatic test_empty_pop();
    send_item(ACT_POP, 8'h00, 1'b0);
    send_item(ACT_POP, 8'hFF, 1'b1);
  endtask

  // Single-byte packets at the byte extremes, a two-byte packet, then a full drain.
  task automatic test_byte_extremes();
    send_item(ACT_PUSH, 8'h00, 1'b1);
    send_item(ACT_PUSH, 8'hFF, 1'b1);
    send_item(ACT_PUSH, 8'hA5, 1'b0);
    send_item(ACT_PUSH, 8'h5A, 1'b1);
    repeat (4) send_item(ACT_POP, byte_t'($urandom), 1'b0);
  endtask

  // A pop between two bytes frees the head slot but leaves the tail slot in place.
  task automatic test_pop_mid_packet();
    send_item(ACT_PUSH, 8'h11, 1'b1);
    send_item(ACT_PUSH, 8'h22, 1'b0);
    send_item(ACT_POP, 8'h99, 1'b1);
    send_item(ACT_PUSH, 8'h33, 1'b1);
    send_item(ACT_POP, 8'h66, 1'b0);
    send_item(ACT_POP, 8'h66, 1'b0);
  endtask

  // Packets at the slot size and one and three bytes beyond it.
  task automatic test_length_limits();
    send_packet(SLOT_BYTES, 0);
    send_item(ACT_POP, 8'h00, 1'b0);
    send_packet(SLOT_BYTES + 1, 0);
    send_packet(SLOT_BYTES + 3, 0);
    send_item(ACT_POP, 8'h00, 1'b0);
  endtask

  // Fills every slot, then drops packets that start while full, including one
  // that sees a pop in the middle, and drains past empty.
  task automatic test_full_drop();
    for (int i = 0; i < SLOT_COUNT; i++)
      send_item(ACT_PUSH, byte_t'($urandom), 1'b1);
    send_packet(2, 0);
    send_item(ACT_PUSH, byte_t'($urandom), 1'b0);
    send_item(ACT_POP, byte_t'($urandom), 1'b0);
    send_item(ACT_PUSH, byte_t'($urandom), 1'b1);
    send_packet(3, 0);
    repeat (SLOT_COUNT + 1) send_item(ACT_POP, byte_t'($urandom), 1'b1);
  endtask

  // Mostly well-formed packets with random content; fill and drain phases
  // alternate so that full drops and empty pops both occur.
  task automatic test_random_traffic();
    int  pick;
    int  plen;
    bit  draining;
    draining = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 39) == 0)
        no_gaps = ~no_gaps;
      if ($urandom_range(0, 19) == 0)
        draining = ~draining;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // Noise: any action, any flag.
        send_item(action_t'($urandom_range(0, 1)), byte_t'($urandom),
                  logic'($urandom_range(0, 1)));
      end else if (pick < (draining ? 55 : 18)) begin
        send_item(ACT_POP, byte_t'($urandom), logic'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          plen = $urandom_range(1, 6);
        else if (pick < 90)
          plen = $urandom_range(7, 24);
        else if (pick < 96)
          plen = $urandom_range(SLOT_BYTES - 4, SLOT_BYTES);
        else
          plen = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 4);
        send_packet(plen, 5);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Output side: stalls for a random number of cycles after each transaction.
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each output transaction with the oldest prediction.
  always @(posedge clk) begin
    psf_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rx_wait = no_gaps ? 0 : $urandom_range(0, 9);
      result_index++;
      if (fifo_outputs_due.size() == 0) begin
        report_mismatch("unexpected transaction, kind", m_axis_tuser, -1);
      end else begin
        want = fifo_outputs_due.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[7:0] !== want.out_byte)
          report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
        if (m_axis_tdata[14:8] !== want.size)
          report_mismatch("packet_size", m_axis_tdata[14:8], want.size);
        if (m_axis_tdata[15] !== 1'b0)
          report_mismatch("tdata pad bit", m_axis_tdata[15], 0);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    rx_wait = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    mismatch_count = 0;
    result_index = 0;
    items_sent = 0;
    head_idx = 0;
    stored_packets = 0;
    fill_idx = 0;
    drop_state = DROP_NONE;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pop();
    test_byte_extremes();
    test_pop_mid_packet();
    test_length_limits();
    test_full_drop();
    test_random_traffic();

    // Drain all predicted results, then watch for stray transactions.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (fifo_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/psf_pkg.sv
hw/rtl/psf_ctrl.sv
hw/rtl/psf_datapath.sv
hw/rtl/packet_slot_fifo.sv
tb/sv/packet_slot_fifo_tb.sv
